// ===== rtl/bfwa_pkg.sv =====
// Shared constants, types and state codes of the bounded FIFO window average.
package bfwa_pkg;

  localparam int CAPACITY = 5;

  localparam int ID_W    = 12;
  localparam int VALUE_W = 9;
  localparam int MEAN_W  = 9;
  localparam int OCC_W   = 3;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SUM_W  = $clog2(CAPACITY * ((1 << VALUE_W) - 1) + 1);
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/bfwa_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the window sum over the count.
module bfwa_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bfwa_pkg::SUM_W-1:0]       dividend,
  input  logic [bfwa_pkg::CNT_W-1:0]       divisor,
  output logic [bfwa_pkg::SUM_W-1:0]       quotient,
  output logic [bfwa_pkg::CNT_W-1:0]       remainder,
  output bfwa_pkg::div_status_t            status
);

  logic [bfwa_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [bfwa_pkg::SUM_W-1:0]  quo_r, quo_nxt;
  logic [bfwa_pkg::CNT_W-1:0]  dvs_r;
  logic [bfwa_pkg::STEP_W-1:0] step_r;
  logic                        busy_r;
  logic                        done_r;

  logic [bfwa_pkg::CNT_W:0] shifted;
  logic [bfwa_pkg::CNT_W:0] diff;
  logic                     ge;

  always_comb begin
    shifted = {rem_r, quo_r[bfwa_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[bfwa_pkg::CNT_W-1:0] : shifted[bfwa_pkg::CNT_W-1:0];
    quo_nxt = {quo_r[bfwa_pkg::SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= bfwa_pkg::STEP_W'(bfwa_pkg::SUM_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient    = quo_r;
  assign remainder   = rem_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== rtl/bounded_fifo_window_average.sv =====
// Top level of the bounded FIFO window average: record ring, sequencer, result register.
//
// Input channel (in_valid/in_ready): one request per operation. in_kind 0 inserts
// (in_record_id, in_record_value); when the queue already holds CAPACITY records the
// oldest is dropped first. in_kind 1 removes the oldest record.
// Result channel (out_valid/out_ready): exactly one result per request, in order.
// An insert answers with the mean of the stored values, rounded half to even; a remove
// answers with the popped id, or with out_empty_error set when the queue was empty.
// out_occupancy is the record count after the operation, taken modulo 8.
// Timing: the ring, count and sum update at the accepting edge. A remove result goes
// straight to the sequencer's hold state; an insert first runs the one-bit-per-cycle
// divider over SUM_W quotient bits and then registers its rounded mean. in_ready stays low
// until the result moves into the result register, so a new request is not accepted
// while the previous one is still being worked.
// The result register lets the block take and work a new request while the previous
// result waits; a finished result then holds until out_ready frees the register.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
module bounded_fifo_window_average (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [bfwa_pkg::ID_W-1:0]      in_record_id,
  input  logic [bfwa_pkg::VALUE_W-1:0]   in_record_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_done_kind,
  output logic [bfwa_pkg::MEAN_W-1:0]    out_window_mean,
  output logic [bfwa_pkg::ID_W-1:0]      out_removed_id,
  output logic                           out_empty_error,
  output logic [bfwa_pkg::OCC_W-1:0]     out_occupancy
);

  bfwa_pkg::state_t state_r, state_nxt;

  logic [bfwa_pkg::ID_W-1:0]    id_ring_r    [bfwa_pkg::CAPACITY];
  logic [bfwa_pkg::VALUE_W-1:0] value_ring_r [bfwa_pkg::CAPACITY];

  logic [bfwa_pkg::SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [bfwa_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bfwa_pkg::SUM_W-1:0]  sum_r, sum_nxt;

  logic                         res_kind_r, res_kind_nxt;
  logic [bfwa_pkg::MEAN_W-1:0]  res_mean_r, res_mean_nxt;
  logic [bfwa_pkg::ID_W-1:0]    res_id_r, res_id_nxt;
  logic                         res_err_r, res_err_nxt;
  logic [bfwa_pkg::OCC_W-1:0]   res_occ_r, res_occ_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r;
  logic [bfwa_pkg::MEAN_W-1:0]  out_mean_r;
  logic [bfwa_pkg::ID_W-1:0]    out_id_r;
  logic                         out_err_r;
  logic [bfwa_pkg::OCC_W-1:0]   out_occ_r;

  logic                          accept;
  logic                          full;
  logic                          load_out;
  logic                          ring_wr;
  logic [bfwa_pkg::SLOT_W-1:0]   wr_slot;
  logic [bfwa_pkg::SLOT_W-1:0]   oldest_inc;
  logic [bfwa_pkg::SLOT_W:0]     tail_sum;
  logic [bfwa_pkg::SLOT_W-1:0]   tail_slot;
  logic                          div_start;
  logic [bfwa_pkg::SUM_W-1:0]    div_q;
  logic [bfwa_pkg::CNT_W-1:0]    div_r;
  bfwa_pkg::div_status_t         div_status;
  logic [bfwa_pkg::CNT_W:0]      twice_r;
  logic                          round_up;

  bfwa_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (sum_nxt),
    .divisor   (count_nxt),
    .quotient  (div_q),
    .remainder (div_r),
    .status    (div_status)
  );

  always_comb begin
    accept     = in_valid && in_ready;
    full       = (count_r == bfwa_pkg::CNT_W'(bfwa_pkg::CAPACITY));
    oldest_inc = (oldest_r == bfwa_pkg::SLOT_W'(bfwa_pkg::CAPACITY - 1)) ?
                 '0 : oldest_r + 1'b1;
    tail_sum   = (bfwa_pkg::SLOT_W+1)'(oldest_r) + (bfwa_pkg::SLOT_W+1)'(count_r);
    tail_slot  = (tail_sum >= (bfwa_pkg::SLOT_W+1)'(bfwa_pkg::CAPACITY)) ?
                 bfwa_pkg::SLOT_W'(tail_sum - (bfwa_pkg::SLOT_W+1)'(bfwa_pkg::CAPACITY)) :
                 tail_sum[bfwa_pkg::SLOT_W-1:0];
    twice_r    = {div_r, 1'b0};
    round_up   = (twice_r > {1'b0, count_r}) ||
                 ((twice_r == {1'b0, count_r}) && div_q[0]);
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    oldest_nxt   = oldest_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    ring_wr      = 1'b0;
    wr_slot      = tail_slot;
    div_start    = 1'b0;
    load_out     = 1'b0;
    res_kind_nxt = res_kind_r;
    res_mean_nxt = res_mean_r;
    res_id_nxt   = res_id_r;
    res_err_nxt  = res_err_r;
    res_occ_nxt  = res_occ_r;

    unique case (state_r)
      bfwa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_kind_nxt = in_kind;
          if (!in_kind) begin
            ring_wr   = 1'b1;
            div_start = 1'b1;
            if (full) begin
              wr_slot    = oldest_r;
              oldest_nxt = oldest_inc;
              sum_nxt    = sum_r + bfwa_pkg::SUM_W'(in_record_value)
                           - bfwa_pkg::SUM_W'(value_ring_r[oldest_r]);
            end else begin
              count_nxt = count_r + 1'b1;
              sum_nxt   = sum_r + bfwa_pkg::SUM_W'(in_record_value);
            end
            res_id_nxt  = '0;
            res_err_nxt = 1'b0;
            res_occ_nxt = bfwa_pkg::OCC_W'(count_nxt);
            state_nxt   = bfwa_pkg::S_DIV;
          end else begin
            res_mean_nxt = '0;
            if (count_r == '0) begin
              res_id_nxt  = '0;
              res_err_nxt = 1'b1;
            end else begin
              res_id_nxt  = id_ring_r[oldest_r];
              res_err_nxt = 1'b0;
              oldest_nxt  = oldest_inc;
              count_nxt   = count_r - 1'b1;
              sum_nxt     = sum_r - bfwa_pkg::SUM_W'(value_ring_r[oldest_r]);
            end
            res_occ_nxt = bfwa_pkg::OCC_W'(count_nxt);
            state_nxt   = bfwa_pkg::S_HOLD;
          end
        end
      end
      bfwa_pkg::S_DIV: begin
        if (div_status.done) begin
          res_mean_nxt = div_q[bfwa_pkg::MEAN_W-1:0] + bfwa_pkg::MEAN_W'(round_up);
          state_nxt    = bfwa_pkg::S_HOLD;
        end
      end
      bfwa_pkg::S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = bfwa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfwa_pkg::S_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfwa_pkg::S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_wr && accept) begin
      id_ring_r[wr_slot]    <= in_record_id;
      value_ring_r[wr_slot] <= in_record_value;
    end
    res_kind_r <= res_kind_nxt;
    res_mean_r <= res_mean_nxt;
    res_id_r   <= res_id_nxt;
    res_err_r  <= res_err_nxt;
    res_occ_r  <= res_occ_nxt;
    if (load_out) begin
      out_kind_r <= res_kind_r;
      out_mean_r <= res_mean_r;
      out_id_r   <= res_id_r;
      out_err_r  <= res_err_r;
      out_occ_r  <= res_occ_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_done_kind   = out_kind_r;
  assign out_window_mean = out_mean_r;
  assign out_removed_id  = out_id_r;
  assign out_empty_error = out_err_r;
  assign out_occupancy   = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bfwa_pkg::CNT_W'(bfwa_pkg::CAPACITY))
    else $error("record count above capacity");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0))
    else $error("nonzero sum on empty queue");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_error) |->
      (out_done_kind && (out_occupancy == '0) && (out_removed_id == '0)))
    else $error("empty error with inconsistent fields");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == bfwa_pkg::S_DIV))
    else $error("divider finished outside divide state");

  a_div_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_kind) |=> (div_status.busy && (state_r == bfwa_pkg::S_DIV)))
    else $error("insert did not start the divider");

endmodule

// ===== tb/tb_bounded_fifo_window_average.sv =====
// Self-checking testbench for the bounded FIFO window average: directed table, random requests.
`timescale 1ns / 1ps

module tb_bounded_fifo_window_average;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef struct packed {
    logic                         done_kind;
    logic [bfwa_pkg::MEAN_W-1:0]  window_mean;
    logic [bfwa_pkg::ID_W-1:0]    removed_id;
    logic                         empty_error;
    logic [bfwa_pkg::OCC_W-1:0]   occupancy;
  } window_result_t;

  typedef struct packed {
    op_t                          op;
    logic [bfwa_pkg::ID_W-1:0]    record_id;
    logic [bfwa_pkg::VALUE_W-1:0] record_value;
    logic                         typed;
    window_result_t               typed_result;
  } request_row_t;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_PER_PHASE = 575;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int TAIL_CYCLES      = 2 * bfwa_pkg::SUM_W + 8;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PRINT_CAP        = 40;
  localparam window_result_t NO_RESULT = '0;
  localparam int DIRECTED_ROWS    = 25;

  localparam request_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_REMOVE, 12'h000, 9'h000, 1'b1, '{1'b1, 9'd0,   12'h000, 1'b1, 3'd0}},
    '{OP_INSERT, 12'hFFF, 9'h1FF, 1'b1, '{1'b0, 9'd511, 12'h000, 1'b0, 3'd1}},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b1, '{1'b1, 9'd0,   12'hFFF, 1'b0, 3'd0}},
    '{OP_REMOVE, 12'h5A5, 9'h0A5, 1'b1, '{1'b1, 9'd0,   12'h000, 1'b1, 3'd0}},
    '{OP_INSERT, 12'h000, 9'h000, 1'b1, '{1'b0, 9'd0,   12'h000, 1'b0, 3'd1}},
    '{OP_INSERT, 12'h001, 9'h001, 1'b1, '{1'b0, 9'd0,   12'h000, 1'b0, 3'd2}},
    '{OP_INSERT, 12'hAAA, 9'h155, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'h555, 9'h0AA, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'h123, 9'h1FF, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'h456, 9'h1FF, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'h789, 9'h1FF, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'hFFE, 9'h1FF, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'hFFD, 9'h1FF, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'hFFC, 9'h1FF, 1'b1, '{1'b0, 9'd511, 12'h000, 1'b0, 3'd5}},
    '{OP_REMOVE, 12'hFFF, 9'h1FF, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b1, '{1'b1, 9'd0,   12'h000, 1'b1, 3'd0}},
    '{OP_INSERT, 12'h00A, 9'h001, 1'b0, NO_RESULT},
    '{OP_INSERT, 12'h00B, 9'h002, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b0, NO_RESULT},
    '{OP_REMOVE, 12'h000, 9'h000, 1'b1, '{1'b1, 9'd0,   12'h000, 1'b1, 3'd0}}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_kind;
  logic [bfwa_pkg::ID_W-1:0]    in_record_id;
  logic [bfwa_pkg::VALUE_W-1:0] in_record_value;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_done_kind;
  logic [bfwa_pkg::MEAN_W-1:0]  out_window_mean;
  logic [bfwa_pkg::ID_W-1:0]    out_removed_id;
  logic                         out_empty_error;
  logic [bfwa_pkg::OCC_W-1:0]   out_occupancy;

  logic [bfwa_pkg::ID_W-1:0]    ring_ids [bfwa_pkg::CAPACITY];
  logic [bfwa_pkg::VALUE_W-1:0] ring_values [bfwa_pkg::CAPACITY];
  int                           head_slot;
  int                           record_count;
  int                           window_sum;

  window_result_t     pending_results [$];
  window_result_t     observed;
  window_result_t     awaited;
  int                 mismatch_count;
  int                 cycle_count;
  int                 phase_no;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 hold_left;
  bit                 pressure_done;

  bounded_fifo_window_average u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_record_id    (in_record_id),
    .in_record_value (in_record_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_done_kind   (out_done_kind),
    .out_window_mean (out_window_mean),
    .out_removed_id  (out_removed_id),
    .out_empty_error (out_empty_error),
    .out_occupancy   (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic window_result_t predict_window(
    input op_t op,
    input logic [bfwa_pkg::ID_W-1:0] rid,
    input logic [bfwa_pkg::VALUE_W-1:0] rval);
    window_result_t r;
    int slot;
    int q;
    int rem;
    r = '0;
    r.done_kind = op;
    if (op == OP_INSERT) begin
      if (record_count >= bfwa_pkg::CAPACITY) begin
        window_sum -= int'(ring_values[head_slot]);
        head_slot = (head_slot + 1) % bfwa_pkg::CAPACITY;
        record_count--;
      end
      slot = (head_slot + record_count) % bfwa_pkg::CAPACITY;
      ring_ids[slot] = rid;
      ring_values[slot] = rval;
      window_sum += int'(rval);
      record_count++;
      q = window_sum / record_count;
      rem = window_sum % record_count;
      if (2 * rem > record_count || (2 * rem == record_count && q % 2 == 1)) q++;
      r.window_mean = q[bfwa_pkg::MEAN_W-1:0];
    end else if (record_count == 0) begin
      r.empty_error = 1'b1;
    end else begin
      r.removed_id = ring_ids[head_slot];
      window_sum -= int'(ring_values[head_slot]);
      head_slot = (head_slot + 1) % bfwa_pkg::CAPACITY;
      record_count--;
    end
    r.occupancy = record_count[bfwa_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    if (mismatch_count < PRINT_CAP)
      $display("[%0d] mismatch %s: got %0d, expected %0d", cycle_count, field, got, exp_val);
    mismatch_count++;
  endtask

  task automatic send_request(input op_t op, input logic [bfwa_pkg::ID_W-1:0] rid,
                              input logic [bfwa_pkg::VALUE_W-1:0] rval, input logic typed,
                              input window_result_t typed_result);
    window_result_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= op;
    in_record_id    <= rid;
    in_record_value <= rval;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = predict_window(op, rid, rval);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bounded_fifo_window_average regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      observed = '{out_done_kind, out_window_mean, out_removed_id, out_empty_error,
                   out_occupancy};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, done_kind", int'(observed.done_kind), -1);
      end else begin
        awaited = pending_results.pop_front();
        if (observed.done_kind !== awaited.done_kind)
          report_mismatch("done_kind", int'(observed.done_kind),
                          int'(awaited.done_kind));
        if (observed.window_mean !== awaited.window_mean)
          report_mismatch("window_mean", int'(observed.window_mean),
                          int'(awaited.window_mean));
        if (observed.removed_id !== awaited.removed_id)
          report_mismatch("removed_id", int'(observed.removed_id),
                          int'(awaited.removed_id));
        if (observed.empty_error !== awaited.empty_error)
          report_mismatch("empty_error", int'(observed.empty_error),
                          int'(awaited.empty_error));
        if (observed.occupancy !== awaited.occupancy)
          report_mismatch("occupancy", int'(observed.occupancy),
                          int'(awaited.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (phase_no == 2 && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int n;
    int insert_bias;
    op_t op;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= OP_INSERT;
    in_record_id    <= '0;
    in_record_value <= '0;
    out_ready       <= 1'b0;
    head_slot      = 0;
    record_count   = 0;
    window_sum     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    phase_no       = 0;
    send_idle_pct  = 29;
    recv_idle_pct  = 64;
    hold_left      = 0;
    pressure_done  = 1'b0;
    insert_bias    = 50;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0:       begin send_idle_pct = 29; recv_idle_pct = 64; end
        1:       begin send_idle_pct = 64; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      if (phase_no == 0)
        for (n = 0; n < DIRECTED_ROWS; n++)
          send_request(DIRECTED[n].op, DIRECTED[n].record_id, DIRECTED[n].record_value,
                       DIRECTED[n].typed, DIRECTED[n].typed_result);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 20 == 0)
          case ($urandom_range(0, 2))
            0:       insert_bias = 20;
            1:       insert_bias = 50;
            default: insert_bias = 85;
          endcase
        op = ($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_REMOVE;
        send_request(op, bfwa_pkg::ID_W'($urandom_range(0, 4095)),
                     bfwa_pkg::VALUE_W'($urandom_range(0, 511)), 1'b0, NO_RESULT);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("bounded_fifo_window_average regression: pass");
    else
      $display("bounded_fifo_window_average regression: fail");
    $finish;
  end

endmodule

// ===== bounded_fifo_window_average.f =====
rtl/bfwa_pkg.sv
rtl/bfwa_divider.sv
rtl/bounded_fifo_window_average.sv
tb/tb_bounded_fifo_window_average.sv
